// File: sv/aff2d_pkg.sv
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared widths, opcodes and the quarter-wave sine table builder for the
// 2x3 affine matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aff2d_pkg;

	localparam int DATA_W          = 32;
	localparam int OPC_W           = 5;
	localparam int ANGLE_W         = 16;
	localparam int LIMIT_W         = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int SINE_BITS_DEF   = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_SINGULAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE = 2'd1;

	localparam logic [OPC_W-1:0] OP_IDENT     = 5'd0;
	localparam logic [OPC_W-1:0] OP_LOAD      = 5'd1;
	localparam logic [OPC_W-1:0] OP_PRE_MUL   = 5'd2;
	localparam logic [OPC_W-1:0] OP_POST_MUL  = 5'd3;
	localparam logic [OPC_W-1:0] OP_PRE_ROT   = 5'd4;
	localparam logic [OPC_W-1:0] OP_POST_ROT  = 5'd5;
	localparam logic [OPC_W-1:0] OP_PRE_TRAN  = 5'd6;
	localparam logic [OPC_W-1:0] OP_POST_TRAN = 5'd7;
	localparam logic [OPC_W-1:0] OP_PRE_SCL   = 5'd8;
	localparam logic [OPC_W-1:0] OP_POST_SCL  = 5'd9;
	localparam logic [OPC_W-1:0] OP_PRE_SHX   = 5'd10;
	localparam logic [OPC_W-1:0] OP_POST_SHX  = 5'd11;
	localparam logic [OPC_W-1:0] OP_PRE_SHY   = 5'd12;
	localparam logic [OPC_W-1:0] OP_POST_SHY  = 5'd13;
	localparam logic [OPC_W-1:0] OP_INVERT    = 5'd14;
	localparam logic [OPC_W-1:0] OP_LP_INV    = 5'd15;
	localparam logic [OPC_W-1:0] OP_APPLY_PT  = 5'd16;
	localparam logic [OPC_W-1:0] OP_APPLY_VEC = 5'd17;
	localparam logic [OPC_W-1:0] OP_APPLY_TR  = 5'd18;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Sine table entry i of a quarter wave with 2^stb steps, frac fraction bits.
	function automatic logic [DATA_W-1:0] sine_entry(input int unsigned i,
		input int frac, input int stb);
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		int sh;
		if (i >= (32'd1 << stb)) begin
			return DATA_W'(64'd1 << frac);
		end
		x = (HALF_PI_Q30 * 64'(i)) >> stb;
		sum = x;
		term = x;
		for (int k = 1; k <= 8; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if ((k % 2) == 1) sum = sum - term;
			else sum = sum + term;
		end
		sh = 30 - frac;
		if (sh > 0) sum = (sum + (64'd1 << (sh - 1))) >> sh;
		if (sum > (64'd1 << frac)) sum = 64'd1 << frac;
		return DATA_W'(sum);
	endfunction

endpackage

`default_nettype wire

// File: sv/affine_2d_matrix_engine_unit.sv
// ----------------------------------------------------------------------------
// affine_2d_matrix_engine_unit
// Holds one 2x3 affine matrix in signed fixed point and applies one opcode
// per request through a bit-serial multiply-accumulate sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request: opcode, operand
//   matrix, arg_x/arg_y and angle. in_stall is high while a request is in work.
//   Output channel (out_valid/out_stall) returns the matrix after the step,
//   out_x/out_y, determinant and status. The result sits in an output register,
//   so a new request is taken while a finished result waits to be taken.
//   Config channel (cfg_valid/cfg_ready, always ready) writes singular_limit
//   (index 0) and relative_limit (index 1); other indexes are dropped.
// Datapath: every product goes through one shift-add multiplier, one
//   multiplier bit per cycle; each multiply-accumulate step forms two products.
//   Identity, load, translate-add and unused opcodes skip the multiplier;
//   apply, length-preserving inverse and matrix products run multiply-accumulate
//   steps only, and the inverse adds a singularity check and the one-bit-per-cycle
//   restoring divider for the reciprocal.
// Reset: asynchronous, loads the identity matrix and the default limits.
// Stall: a stalled result holds; the next request completes up to its
//   commit step and then waits there until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_2d_matrix_engine_unit
	import aff2d_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OPC_W-1:0]     opcode,
	input  wire logic [DATA_W-1:0]    operand_00,
	input  wire logic [DATA_W-1:0]    operand_01,
	input  wire logic [DATA_W-1:0]    operand_10,
	input  wire logic [DATA_W-1:0]    operand_11,
	input  wire logic [DATA_W-1:0]    operand_20,
	input  wire logic [DATA_W-1:0]    operand_21,
	input  wire logic [DATA_W-1:0]    arg_x,
	input  wire logic [DATA_W-1:0]    arg_y,
	input  wire logic [ANGLE_W-1:0]   angle,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [DATA_W-1:0]         mat_00,
	output logic [DATA_W-1:0]         mat_01,
	output logic [DATA_W-1:0]         mat_10,
	output logic [DATA_W-1:0]         mat_11,
	output logic [DATA_W-1:0]         mat_20,
	output logic [DATA_W-1:0]         mat_21,
	output logic [DATA_W-1:0]         out_x,
	output logic [DATA_W-1:0]         out_y,
	output logic [DATA_W-1:0]         determinant,
	output logic                      status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LIMIT_W-1:0]   cfg_data
);

	localparam int W       = DATA_W;
	localparam int ACC_W   = 2 * DATA_W;
	localparam int N_SIN   = 1 << SINE_TABLE_BITS;
	localparam int SIDX_W  = SINE_TABLE_BITS + 1;
	localparam int DIV_N   = 2 * FRAC_BITS + 1;
	localparam int DCNT_W  = $clog2(DIV_N);
	localparam int MCNT_W  = $clog2(DATA_W);
	localparam logic [W-1:0] ONE = W'(64'd1 << FRAC_BITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam int UOP_W = 4;
	localparam logic [UOP_W-1:0] UOP_INV_CHECK = 4'd2;
	localparam logic [UOP_W-1:0] UOP_N_INV     = 4'd10;
	localparam logic [UOP_W-1:0] UOP_N_MAT     = 4'd6;
	localparam logic [UOP_W-1:0] UOP_N_PAIR    = 4'd2;
	localparam logic [UOP_W-1:0] UOP_NONE      = 4'd0;

	// ------------------------------------------------------------------
	// Quarter-wave sine table, built at elaboration.
	// ------------------------------------------------------------------
	logic [W-1:0] sin_rom [N_SIN+1];
	for (genvar g = 0; g <= N_SIN; g++) begin : g_rom
		assign sin_rom[g] = sine_entry(g, FRAC_BITS, SINE_TABLE_BITS);
	end

	logic [SIDX_W-1:0] sidx;
	logic [SIDX_W-1:0] cidx;
	logic [W-1:0]      rom_a;
	logic [W-1:0]      rom_b;
	logic [W-1:0]      sin_v;
	logic [W-1:0]      cos_v;

	assign sidx  = SIDX_W'(angle[13 -: SINE_TABLE_BITS]);
	assign cidx  = SIDX_W'(N_SIN) - sidx;
	assign rom_a = sin_rom[sidx];
	assign rom_b = sin_rom[cidx];

	always_comb begin
		case (angle[15:14])
			2'd0:    begin sin_v = rom_a;      cos_v = rom_b;      end
			2'd1:    begin sin_v = rom_b;      cos_v = -rom_a;     end
			2'd2:    begin sin_v = -rom_a;     cos_v = -rom_b;     end
			default: begin sin_v = -rom_b;     cos_v = rom_a;      end
		endcase
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [2:0]         state_q;
	logic [W-1:0]       mat_q [6];
	logic [W-1:0]       opm_q [6];
	logic [OPC_W-1:0]   op_q;
	logic [W-1:0]       x_q, y_q, s_q, c_q;
	logic [LIMIT_W-1:0] sl_q, rl_q;
	logic [W-1:0]       tmp_q [10];
	logic [UOP_W-1:0]   uop_q;
	logic [UOP_W-1:0]   nuop_q;
	logic               ph_q;
	logic [MCNT_W-1:0]  mcnt_q;
	logic [ACC_W-1:0]   mcand_q;
	logic [W-1:0]       mplier_q;
	logic [ACC_W-1:0]   acc_q;
	logic [W-1:0]       s1_q;
	logic [W-1:0]       mag_q;
	logic               dneg_q;
	logic [W:0]         rem_q;
	logic [W-1:0]       quo_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [W-1:0]       id_q;
	logic               fail_q;
	logic               out_valid_q;
	logic [W-1:0]       omat_q [6];
	logic [W-1:0]       ox_q, oy_q, det_q;
	logic               status_q;

	logic in_acc;
	logic out_free;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Step decode: operands of the current multiply-accumulate step
	// ------------------------------------------------------------------
	logic [W-1:0] tm [6];
	logic [W-1:0] lv [6];
	logic [W-1:0] mv [6];
	logic         is_pre, is_matop;
	logic [W-1:0] ua, ub, uc, ud, ue;
	logic         usep, uneg2, unegr;
	logic [2:0]   li, mj;

	always_comb begin
		is_matop = 1'b1;
		is_pre   = 1'b0;
		for (int k = 0; k < 6; k++) tm[k] = '0;
		case (op_q)
			OP_PRE_MUL, OP_POST_MUL: begin
				for (int k = 0; k < 6; k++) tm[k] = opm_q[k];
			end
			OP_PRE_ROT, OP_POST_ROT: begin
				tm[0] = c_q; tm[1] = s_q; tm[2] = -s_q; tm[3] = c_q;
			end
			OP_PRE_TRAN: begin
				tm[0] = ONE; tm[3] = ONE; tm[4] = x_q; tm[5] = y_q;
			end
			OP_PRE_SCL, OP_POST_SCL: begin
				tm[0] = x_q; tm[3] = y_q;
			end
			OP_PRE_SHX, OP_POST_SHX: begin
				tm[0] = ONE; tm[1] = y_q; tm[3] = ONE;
			end
			OP_PRE_SHY, OP_POST_SHY: begin
				tm[0] = ONE; tm[2] = x_q; tm[3] = ONE;
			end
			default: is_matop = 1'b0;
		endcase
		is_pre = !op_q[0];
		for (int k = 0; k < 6; k++) begin
			lv[k] = is_pre ? tm[k] : mat_q[k];
			mv[k] = is_pre ? mat_q[k] : tm[k];
		end

		li = {uop_q[2:1], 1'b0};
		mj = {2'b00, uop_q[0]};
		ua = '0; ub = '0; uc = '0; ud = '0; ue = '0;
		usep = 1'b0; uneg2 = 1'b0; unegr = 1'b0;
		if (is_matop) begin
			ua = lv[li]; ub = mv[mj];
			uc = lv[li + 3'd1]; ud = mv[mj + 3'd2];
			ue = (uop_q[2:1] == 2'd2) ? mv[mj + 3'd4] : '0;
		end else begin
			case (op_q)
				OP_APPLY_PT, OP_APPLY_VEC: begin
					ua = x_q; ub = mat_q[mj];
					uc = y_q; ud = mat_q[mj + 3'd2];
					ue = (op_q == OP_APPLY_PT) ? mat_q[mj + 3'd4] : '0;
				end
				OP_APPLY_TR: begin
					ua = x_q; ub = mat_q[{1'b0, uop_q[0], 1'b0}];
					uc = y_q; ud = mat_q[{1'b0, uop_q[0], 1'b1}];
				end
				OP_LP_INV: begin
					usep = 1'b1; uneg2 = 1'b1;
					if (!uop_q[0]) begin
						ua = mat_q[2]; ub = mat_q[5]; uc = mat_q[3]; ud = mat_q[4];
					end else begin
						ua = mat_q[1]; ub = mat_q[4]; uc = mat_q[0]; ud = mat_q[5];
					end
				end
				OP_INVERT: begin
					case (uop_q)
						4'd0: begin ua = mat_q[0]; ub = mat_q[3]; end
						4'd1: begin ua = -mat_q[2]; ub = mat_q[1]; end
						4'd2: begin
							usep = 1'b1; uneg2 = 1'b1;
							ua = mat_q[2]; ub = mat_q[5]; uc = mat_q[3]; ud = mat_q[4];
						end
						4'd3: begin
							usep = 1'b1; uneg2 = 1'b1;
							ua = mat_q[1]; ub = mat_q[4]; uc = mat_q[0]; ud = mat_q[5];
						end
						4'd4: begin ua = mat_q[3]; ub = id_q; end
						4'd5: begin ua = mat_q[1]; ub = id_q; unegr = 1'b1; end
						4'd6: begin ua = mat_q[2]; ub = id_q; unegr = 1'b1; end
						4'd7: begin ua = mat_q[0]; ub = id_q; end
						4'd8: begin ua = tmp_q[2]; ub = id_q; end
						default: begin ua = tmp_q[3]; ub = id_q; end
					endcase
				end
				default: ;
			endcase
		end
	end

	function automatic logic [UOP_W-1:0] step_count(input logic [OPC_W-1:0] op);
		case (op)
			OP_PRE_MUL, OP_POST_MUL, OP_PRE_ROT, OP_POST_ROT, OP_PRE_TRAN,
			OP_PRE_SCL, OP_POST_SCL, OP_PRE_SHX, OP_POST_SHX, OP_PRE_SHY,
			OP_POST_SHY: return UOP_N_MAT;
			OP_INVERT: return UOP_N_INV;
			OP_LP_INV, OP_APPLY_PT, OP_APPLY_VEC, OP_APPLY_TR: return UOP_N_PAIR;
			default: return UOP_NONE;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Serial multiplier datapath
	// ------------------------------------------------------------------
	logic [ACC_W-1:0] addend, acc_next;
	logic [W-1:0]     p_now, p_term, step_res;
	logic             mcnt_last;

	assign mcnt_last = (mcnt_q == MCNT_W'(W - 1));
	// The top multiplier bit carries negative weight.
	assign addend   = mplier_q[0] ? (mcnt_last ? -mcand_q : mcand_q) : '0;
	assign acc_next = acc_q + addend;
	assign p_now    = acc_next[FRAC_BITS +: W];
	assign p_term   = uneg2 ? -p_now : p_now;

	always_comb begin
		step_res = (usep ? (s1_q + p_term) : p_now) + ue;
		if (unegr) step_res = -step_res;
	end

	// ------------------------------------------------------------------
	// Inversion checks and reciprocal divider
	// ------------------------------------------------------------------
	logic [W-1:0]     det_v, mag_v, ab0, ab1;
	logic [W:0]       terms_v;
	logic [ACC_W-1:0] lhs_v, rhs_v;
	logic             fail_v;
	logic [W:0]       rem_sh, rem_next;
	logic             q_bit;
	logic [W-1:0]     quo_next;

	assign det_v   = tmp_q[0] + tmp_q[1];
	assign mag_v   = det_v[W-1] ? -det_v : det_v;
	assign ab0     = tmp_q[0][W-1] ? -tmp_q[0] : tmp_q[0];
	assign ab1     = tmp_q[1][W-1] ? -tmp_q[1] : tmp_q[1];
	assign terms_v = {1'b0, ab0} + {1'b0, ab1};
	assign lhs_v   = ACC_W'(mag_v) << FRAC_BITS;
	assign rhs_v   = ACC_W'(rl_q) * ACC_W'(terms_v);
	assign fail_v  = (mag_v <= W'(sl_q)) || (lhs_v < rhs_v);

	assign rem_sh   = {rem_q[W-1:0], (dcnt_q == '0)};
	assign q_bit    = (rem_sh >= {1'b0, mag_q});
	assign rem_next = q_bit ? (rem_sh - {1'b0, mag_q}) : rem_sh;
	assign quo_next = {quo_q[W-2:0], q_bit};

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mat_q[0]    <= ONE;
			mat_q[1]    <= '0;
			mat_q[2]    <= '0;
			mat_q[3]    <= ONE;
			mat_q[4]    <= '0;
			mat_q[5]    <= '0;
			sl_q        <= LIMIT_W'(2);
			rl_q        <= '0;
			out_valid_q <= 1'b0;
			uop_q       <= '0;
			nuop_q      <= '0;
			ph_q        <= 1'b0;
			mcnt_q      <= '0;
			dcnt_q      <= '0;
			fail_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SINGULAR) sl_q <= cfg_data;
				else if (cfg_index == CFG_RELATIVE) rl_q <= cfg_data;
			end
			// Load a finished result, else drop the one just taken.
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						nuop_q  <= step_count(opcode);
						uop_q   <= '0;
						fail_q  <= 1'b0;
						state_q <= (step_count(opcode) == UOP_NONE) ? ST_FIN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					ph_q    <= 1'b0;
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + MCNT_W'(1);
					if (mcnt_last) begin
						if (!ph_q) begin
							ph_q <= 1'b1;
						end else begin
							uop_q <= uop_q + UOP_W'(1);
							if (op_q == OP_INVERT && uop_q == UOP_INV_CHECK - UOP_W'(1))
								state_q <= ST_CHECK;
							else if (uop_q + UOP_W'(1) == nuop_q)
								state_q <= ST_FIN;
							else
								state_q <= ST_LOAD;
						end
					end
				end
				ST_CHECK: begin
					dcnt_q <= '0;
					if (fail_v) begin
						fail_q  <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_N - 1)) state_q <= ST_LOAD;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						case (op_q)
							OP_IDENT: begin
								mat_q[0] <= ONE; mat_q[1] <= '0; mat_q[2] <= '0;
								mat_q[3] <= ONE; mat_q[4] <= '0; mat_q[5] <= '0;
							end
							OP_LOAD: begin
								for (int k = 0; k < 6; k++) mat_q[k] <= opm_q[k];
							end
							OP_POST_TRAN: begin
								mat_q[4] <= mat_q[4] + x_q;
								mat_q[5] <= mat_q[5] + y_q;
							end
							OP_INVERT: begin
								if (!fail_q)
									for (int k = 0; k < 6; k++) mat_q[k] <= tmp_q[k + 4];
							end
							OP_LP_INV: begin
								mat_q[0] <= mat_q[3];  mat_q[1] <= -mat_q[1];
								mat_q[2] <= -mat_q[2]; mat_q[3] <= mat_q[0];
								mat_q[4] <= tmp_q[0];  mat_q[5] <= tmp_q[1];
							end
							default: begin
								if (is_matop)
									for (int k = 0; k < 6; k++) mat_q[k] <= tmp_q[k];
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers: request capture, multiplier, divider, results.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= opcode;
			opm_q[0] <= operand_00;
			opm_q[1] <= operand_01;
			opm_q[2] <= operand_10;
			opm_q[3] <= operand_11;
			opm_q[4] <= operand_20;
			opm_q[5] <= operand_21;
			x_q      <= arg_x;
			y_q      <= arg_y;
			s_q      <= sin_v;
			c_q      <= cos_v;
		end
		case (state_q)
			ST_LOAD: begin
				mcand_q  <= {{W{ua[W-1]}}, ua};
				mplier_q <= ub;
				acc_q    <= '0;
			end
			ST_MUL: begin
				if (mcnt_last && !ph_q) begin
					// Second product of the step: restart or keep the sum.
					s1_q     <= p_now;
					acc_q    <= usep ? '0 : acc_next;
					mcand_q  <= {{W{uc[W-1]}}, uc};
					mplier_q <= ud;
				end else begin
					acc_q    <= acc_next;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				if (mcnt_last && ph_q) tmp_q[uop_q] <= step_res;
			end
			ST_CHECK: begin
				mag_q  <= mag_v;
				dneg_q <= det_v[W-1];
				rem_q  <= '0;
				quo_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (dcnt_q == DCNT_W'(DIV_N - 1)) id_q <= dneg_q ? -quo_next : quo_next;
			end
			ST_FIN: begin
				if (out_free) begin
					ox_q     <= '0;
					oy_q     <= '0;
					det_q    <= '0;
					status_q <= 1'b0;
					for (int k = 0; k < 6; k++) omat_q[k] <= mat_q[k];
					case (op_q)
						OP_IDENT: begin
							omat_q[0] <= ONE; omat_q[1] <= '0; omat_q[2] <= '0;
							omat_q[3] <= ONE; omat_q[4] <= '0; omat_q[5] <= '0;
						end
						OP_LOAD: begin
							for (int k = 0; k < 6; k++) omat_q[k] <= opm_q[k];
						end
						OP_POST_TRAN: begin
							omat_q[4] <= mat_q[4] + x_q;
							omat_q[5] <= mat_q[5] + y_q;
						end
						OP_INVERT: begin
							if (fail_q) begin
								status_q <= 1'b1;
							end else begin
								det_q <= det_v;
								for (int k = 0; k < 6; k++) omat_q[k] <= tmp_q[k + 4];
							end
						end
						OP_LP_INV: begin
							omat_q[0] <= mat_q[3];  omat_q[1] <= -mat_q[1];
							omat_q[2] <= -mat_q[2]; omat_q[3] <= mat_q[0];
							omat_q[4] <= tmp_q[0];  omat_q[5] <= tmp_q[1];
						end
						OP_APPLY_PT, OP_APPLY_VEC, OP_APPLY_TR: begin
							ox_q <= tmp_q[0];
							oy_q <= tmp_q[1];
						end
						default: begin
							if (is_matop)
								for (int k = 0; k < 6; k++) omat_q[k] <= tmp_q[k];
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign mat_00      = omat_q[0];
	assign mat_01      = omat_q[1];
	assign mat_10      = omat_q[2];
	assign mat_11      = omat_q[3];
	assign mat_20      = omat_q[4];
	assign mat_21      = omat_q[5];
	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign determinant = det_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	// The divider never runs on a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (mag_q != '0))
		else $error("divider started with zero divisor");

	// A taken request leaves the idle state on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer idle");

	// A failed inversion reports no determinant.
	a_fail_det: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (det_q == '0))
		else $error("failed inversion with nonzero determinant");

	// Each multiply step starts at multiplier bit zero.
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> (mcnt_q == '0 && !ph_q))
		else $error("multiply step started mid-count");
`endif

endmodule

`default_nettype wire
